/* hw/rtl/kfl_pkg.sv */
// ----------------------------------------------------------------------------
// kfl_pkg
// Types, widths and codes shared by the keyframe position interpolator.
// ----------------------------------------------------------------------------
package kfl_pkg;

    localparam int KEYS_DEFAULT = 64;

    localparam int TICK_W    = 24;
    localparam int POS_W     = 32;
    localparam int DIFF_W    = POS_W + 1;
    localparam int PROD_W    = DIFF_W + TICK_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int MODE_W    = 2;
    localparam int CODE_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    localparam logic [CODE_W-1:0] CASE_EMPTY  = 2'd0;
    localparam logic [CODE_W-1:0] CASE_BEFORE = 2'd1;
    localparam logic [CODE_W-1:0] CASE_AFTER  = 2'd2;
    localparam logic [CODE_W-1:0] CASE_LERP   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_Z = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [TICK_W-1:0]       tick;
        logic signed [POS_W-1:0] key_x;
        logic signed [POS_W-1:0] key_y;
        logic signed [POS_W-1:0] key_z;
    } kfl_in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] out_x;
        logic signed [POS_W-1:0] out_y;
        logic signed [POS_W-1:0] out_z;
        logic [CODE_W-1:0]       case_code;
        logic                    table_full;
    } kfl_out_t;

    typedef struct packed {
        logic [TICK_W-1:0]       tick;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } kfl_key_t;

    typedef struct packed {
        logic              accept;
        logic              idx_last;
        logic              idx_one;
        logic              idx_inc;
        logic              prev_load;
        logic              res_key;
        logic              res_lerp;
        logic [CODE_W-1:0] case_code;
        logic              lane_load;
        logic              mul;
        logic              div_step;
        logic              emit;
    } kfl_cmd_t;

    typedef struct packed {
        logic empty;
        logic tick_lt;
    } kfl_sts_t;

endpackage

/* hw/rtl/kfl_lane.sv */
// ----------------------------------------------------------------------------
// kfl_lane
// One axis of the interpolator: difference, multiply, restoring divide, add.
// ----------------------------------------------------------------------------
module kfl_lane (
    input  logic                             clk,
    input  kfl_pkg::kfl_cmd_t                cmd,
    input  logic signed [kfl_pkg::POS_W-1:0] a,
    input  logic signed [kfl_pkg::POS_W-1:0] b,
    input  logic [kfl_pkg::TICK_W-1:0]       num,
    input  logic [kfl_pkg::TICK_W-1:0]       den,
    output logic signed [kfl_pkg::POS_W-1:0] res
);
    import kfl_pkg::*;

    logic [DIFF_W-1:0]       mag_reg;
    logic [DIFF_W-1:0]       mag_next;
    logic                    neg_reg;
    logic signed [POS_W-1:0] base_reg;
    logic [PROD_W-1:0]       quo_reg;
    logic [PROD_W-1:0]       quo_next;
    logic [TICK_W-1:0]       rem_reg;
    logic [TICK_W-1:0]       rem_next;
    logic signed [DIFF_W-1:0] diff;
    logic [PROD_W-1:0]       prod;
    logic [TICK_W:0]         shifted;
    logic [TICK_W:0]         trial;
    logic                    ge;
    logic [POS_W-1:0]        q;

    assign diff     = $signed({b[POS_W-1], b}) - $signed({a[POS_W-1], a});
    assign mag_next = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign prod     = PROD_W'(mag_reg) * PROD_W'(num);
    assign shifted  = {rem_reg, quo_reg[PROD_W-1]};
    assign trial    = shifted - {1'b0, den};
    assign ge       = (shifted >= {1'b0, den});
    assign q        = quo_reg[POS_W-1:0];
    assign res      = neg_reg ? (base_reg - $signed(q)) : (base_reg + $signed(q));

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (cmd.mul)
        begin
            quo_next = prod;
            rem_next = '0;
        end
        else if (cmd.div_step)
        begin
            quo_next = {quo_reg[PROD_W-2:0], ge};
            rem_next = ge ? trial[TICK_W-1:0] : shifted[TICK_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lane_load)
        begin
            mag_reg  <= mag_next;
            neg_reg  <= diff[DIFF_W-1];
            base_reg <= a;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

endmodule

/* hw/rtl/kfl_dpath.sv */
// ----------------------------------------------------------------------------
// kfl_dpath
// Keyframe memory, search registers, fallback registers, three axis lanes
// and the result and output registers.
// ----------------------------------------------------------------------------
module kfl_dpath #(
    parameter int MAX_KEYS = kfl_pkg::KEYS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  kfl_pkg::kfl_cmd_t                 cmd,
    output kfl_pkg::kfl_sts_t                 sts,
    input  kfl_pkg::kfl_in_t                  in_item,
    output kfl_pkg::kfl_out_t                 out_item,
    input  logic                              cfg_we,
    input  logic [kfl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kfl_pkg::POS_W-1:0]         cfg_data
);
    import kfl_pkg::*;

    localparam int IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W = $clog2(MAX_KEYS + 1);

    kfl_key_t                kf_mem [MAX_KEYS];
    kfl_key_t                rd_reg;
    kfl_key_t                prev_reg;
    kfl_key_t                wr_key;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        idx_next;
    logic [IDX_W-1:0]        last;
    logic [TICK_W-1:0]       tick_reg;
    logic [TICK_W-1:0]       num_reg;
    logic [TICK_W-1:0]       den_reg;
    logic signed [POS_W-1:0] fb_x_reg;
    logic signed [POS_W-1:0] fb_y_reg;
    logic signed [POS_W-1:0] fb_z_reg;
    kfl_out_t                res_reg;
    kfl_out_t                res_next;
    kfl_out_t                out_reg;
    logic                    has_room;
    logic                    do_write;
    logic signed [POS_W-1:0] lerp_x;
    logic signed [POS_W-1:0] lerp_y;
    logic signed [POS_W-1:0] lerp_z;

    assign has_room = (count_reg < CNT_W'(MAX_KEYS));
    assign do_write = cmd.accept && (in_item.mode == MODE_APPEND) && has_room;
    assign last     = IDX_W'(count_reg - CNT_W'(1));
    assign wr_key   = '{tick: in_item.tick, x: in_item.key_x,
                        y: in_item.key_y, z: in_item.key_z};

    assign sts.empty   = (count_reg == '0);
    assign sts.tick_lt = (tick_reg < rd_reg.tick);
    assign out_item    = out_reg;

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            kf_mem[count_reg[IDX_W-1:0]] <= wr_key;
        end
        rd_reg <= kf_mem[idx_reg];
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.accept)
        begin
            if (in_item.mode == MODE_CLEAR)
            begin
                count_next = '0;
            end
            else if (do_write)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.accept)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_last)
        begin
            idx_next = last;
        end
        else if (cmd.idx_one)
        begin
            idx_next = IDX_W'(1);
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        res_next = res_reg;
        if (cmd.accept)
        begin
            res_next = '0;
            if ((in_item.mode == MODE_QUERY) && sts.empty)
            begin
                res_next.out_x     = fb_x_reg;
                res_next.out_y     = fb_y_reg;
                res_next.out_z     = fb_z_reg;
                res_next.case_code = CASE_EMPTY;
            end
            else if (in_item.mode == MODE_APPEND)
            begin
                res_next.table_full = !has_room;
            end
        end
        else if (cmd.res_key)
        begin
            res_next = '{out_x: rd_reg.x, out_y: rd_reg.y, out_z: rd_reg.z,
                         case_code: cmd.case_code, table_full: 1'b0};
        end
        else if (cmd.res_lerp)
        begin
            res_next = '{out_x: lerp_x, out_y: lerp_y, out_z: lerp_z,
                         case_code: cmd.case_code, table_full: 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            fb_x_reg  <= '0;
            fb_y_reg  <= '0;
            fb_z_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FALLBACK_X: fb_x_reg <= cfg_data;
                    REG_FALLBACK_Y: fb_y_reg <= cfg_data;
                    REG_FALLBACK_Z: fb_z_reg <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            tick_reg <= in_item.tick;
        end
        if (cmd.prev_load)
        begin
            prev_reg <= rd_reg;
        end
        if (cmd.lane_load)
        begin
            num_reg <= tick_reg - prev_reg.tick;
            den_reg <= rd_reg.tick - prev_reg.tick;
        end
        res_reg <= res_next;
        if (cmd.emit)
        begin
            out_reg <= res_reg;
        end
    end

    kfl_lane u_lane_x (
        .clk (clk),
        .cmd (cmd),
        .a   (prev_reg.x),
        .b   (rd_reg.x),
        .num (num_reg),
        .den (den_reg),
        .res (lerp_x)
    );

    kfl_lane u_lane_y (
        .clk (clk),
        .cmd (cmd),
        .a   (prev_reg.y),
        .b   (rd_reg.y),
        .num (num_reg),
        .den (den_reg),
        .res (lerp_y)
    );

    kfl_lane u_lane_z (
        .clk (clk),
        .cmd (cmd),
        .a   (prev_reg.z),
        .b   (rd_reg.z),
        .num (num_reg),
        .den (den_reg),
        .res (lerp_z)
    );

endmodule

/* hw/rtl/kfl_ctrl.sv */
// ----------------------------------------------------------------------------
// kfl_ctrl
// Sequencer: accept, boundary checks, linear key search, divide steps and
// hand-off to the output register.
// ----------------------------------------------------------------------------
module kfl_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [kfl_pkg::MODE_W-1:0]   in_mode,
    output logic                         out_valid,
    input  logic                         out_ready,
    output kfl_pkg::kfl_cmd_t            cmd,
    input  kfl_pkg::kfl_sts_t            sts
);
    import kfl_pkg::*;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
    localparam logic [ST_W-1:0] ST_RD0  = 4'd1;
    localparam logic [ST_W-1:0] ST_CHK0 = 4'd2;
    localparam logic [ST_W-1:0] ST_CHKL = 4'd3;
    localparam logic [ST_W-1:0] ST_SRCH = 4'd4;
    localparam logic [ST_W-1:0] ST_MUL  = 4'd5;
    localparam logic [ST_W-1:0] ST_DIV  = 4'd6;
    localparam logic [ST_W-1:0] ST_FIN  = 4'd7;
    localparam logic [ST_W-1:0] ST_EMIT = 4'd8;

    logic [ST_W-1:0]   state_reg;
    logic [ST_W-1:0]   state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              accept;
    logic              out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.accept = accept;
        state_next = state_reg;
        step_next  = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((in_mode == MODE_QUERY) && !sts.empty)
                    begin
                        state_next = ST_RD0;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_RD0:
            begin
                cmd.idx_last = 1'b1;
                state_next   = ST_CHK0;
            end
            ST_CHK0:
            begin
                if (sts.tick_lt)
                begin
                    cmd.res_key   = 1'b1;
                    cmd.case_code = CASE_BEFORE;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    cmd.prev_load = 1'b1;
                    cmd.idx_one   = 1'b1;
                    state_next    = ST_CHKL;
                end
            end
            ST_CHKL:
            begin
                if (!sts.tick_lt)
                begin
                    cmd.res_key   = 1'b1;
                    cmd.case_code = CASE_AFTER;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SRCH;
                end
            end
            ST_SRCH:
            begin
                if (sts.tick_lt)
                begin
                    cmd.lane_load = 1'b1;
                    state_next    = ST_MUL;
                end
                else
                begin
                    cmd.prev_load = 1'b1;
                    cmd.idx_inc   = 1'b1;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_FIN:
            begin
                cmd.res_lerp  = 1'b1;
                cmd.case_code = CASE_LERP;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result loaded over an untaken beat");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted item left no work");

    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_DIV) |-> (step_reg == '0))
        else $error("divide step count outside divide");

    a_fin_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> ($past(state_reg) == ST_DIV))
        else $error("finish without full divide");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid)
        else $error("emitted beat not presented");
`endif

endmodule

/* hw/rtl/keyframe_position_lerp.sv */
// ----------------------------------------------------------------------------
// keyframe_position_lerp
// Position keyframe table with append, clear and interpolated query.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_item carries one command per beat:
// append a keyframe, clear the table, or query a tick. Output channel
// out_valid/out_ready/out_item returns exactly one beat per input beat.
// cfg_we/cfg_index/cfg_data write the fallback translation registers.
// Append, clear and empty-table queries go straight to the emit state. A query
// first reads the first and last keys, then scans the keys one per cycle on
// the single memory read port, then runs a multiply and 57 restoring divide
// steps in three parallel axis lanes. One item is in work at a time; the
// next is accepted once the previous result has moved into the output
// register, so a stalled receiver holds one finished beat and the block
// still takes one more item. Reset empties the table and clears the
// fallbacks; no memory clearing.
// ----------------------------------------------------------------------------
module keyframe_position_lerp #(
    parameter int MAX_KEYS = kfl_pkg::KEYS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  kfl_pkg::kfl_in_t              in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output kfl_pkg::kfl_out_t             out_item,
    input  logic                          cfg_we,
    input  logic [kfl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kfl_pkg::POS_W-1:0]     cfg_data
);
    import kfl_pkg::*;

    kfl_cmd_t cmd;
    kfl_sts_t sts;

    kfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_mode   (in_item.mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    kfl_dpath #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_item   (in_item),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

/* dv/keyframe_position_lerp_check.sv */
// ----------------------------------------------------------------------------
// keyframe_position_lerp_check
// Watches both channels and the fallback write port of the keyframe track.
// Keeps its own keyframe table and fallback translation, predicts each result
// beat from every accepted command beat, and compares each accepted result
// beat field by field with the oldest prediction. It reports the number of
// failures and the number of results still owed.
// ----------------------------------------------------------------------------
module keyframe_position_lerp_check #(
    parameter int MAX_KEYS = kfl_pkg::KEYS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  kfl_pkg::kfl_in_t              in_item,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  kfl_pkg::kfl_out_t             out_item,
    input  logic                          cfg_we,
    input  logic [kfl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kfl_pkg::POS_W-1:0]     cfg_data,
    output int                            mismatches,
    output int                            outstanding
);

    import kfl_pkg::*;

    kfl_key_t                track [MAX_KEYS];
    int unsigned             track_len;
    logic signed [POS_W-1:0] fb_x;
    logic signed [POS_W-1:0] fb_y;
    logic signed [POS_W-1:0] fb_z;
    kfl_out_t                expected_translations [$];
    kfl_out_t                want;
    int                      fail_total;

    function automatic logic signed [POS_W-1:0] blend_axis(
        logic signed [POS_W-1:0] a,
        logic signed [POS_W-1:0] b,
        logic [TICK_W-1:0]       num,
        logic [TICK_W-1:0]       den
    );
        longint diff;
        longint prod;
        longint quo;
        diff = longint'(b) - longint'(a);
        prod = diff * longint'(num);
        quo  = prod / longint'(den);
        return POS_W'(longint'(a) + quo);
    endfunction

    function automatic kfl_out_t apply_command(kfl_in_t cmd);
        kfl_out_t          res;
        int unsigned       last_idx;
        int unsigned       nx;
        int unsigned       pv;
        logic              found;
        logic [TICK_W-1:0] num;
        logic [TICK_W-1:0] den;
        res = '0;
        case (cmd.mode)
            MODE_APPEND:
            begin
                if (track_len >= MAX_KEYS)
                begin
                    res.table_full = 1'b1;
                end
                else
                begin
                    track[track_len].tick = cmd.tick;
                    track[track_len].x    = cmd.key_x;
                    track[track_len].y    = cmd.key_y;
                    track[track_len].z    = cmd.key_z;
                    track_len++;
                end
            end
            MODE_CLEAR:
            begin
                track_len = 0;
            end
            MODE_QUERY:
            begin
                last_idx = track_len - 1;
                if (track_len == 0)
                begin
                    res.out_x     = fb_x;
                    res.out_y     = fb_y;
                    res.out_z     = fb_z;
                    res.case_code = CASE_EMPTY;
                end
                else if (cmd.tick < track[0].tick)
                begin
                    res.out_x     = track[0].x;
                    res.out_y     = track[0].y;
                    res.out_z     = track[0].z;
                    res.case_code = CASE_BEFORE;
                end
                else if (cmd.tick >= track[last_idx].tick)
                begin
                    res.out_x     = track[last_idx].x;
                    res.out_y     = track[last_idx].y;
                    res.out_z     = track[last_idx].z;
                    res.case_code = CASE_AFTER;
                end
                else
                begin
                    nx    = last_idx;
                    found = 1'b0;
                    for (int unsigned i = 1; i < track_len; i++)
                    begin
                        if (!found && cmd.tick < track[i].tick)
                        begin
                            nx    = i;
                            found = 1'b1;
                        end
                    end
                    pv  = nx - 1;
                    num = cmd.tick - track[pv].tick;
                    den = track[nx].tick - track[pv].tick;
                    res.out_x     = blend_axis(track[pv].x, track[nx].x, num, den);
                    res.out_y     = blend_axis(track[pv].y, track[nx].y, num, den);
                    res.out_z     = blend_axis(track[pv].z, track[nx].z, num, den);
                    res.case_code = CASE_LERP;
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_len  = 0;
            fb_x       = '0;
            fb_y       = '0;
            fb_z       = '0;
            fail_total = 0;
            expected_translations.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FALLBACK_X: fb_x = cfg_data;
                    REG_FALLBACK_Y: fb_y = cfg_data;
                    REG_FALLBACK_Z: fb_z = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_translations.size() == 0)
                begin
                    if (fail_total < 10)
                        $display("unexpected beat at %0t: x=%h y=%h z=%h case=%0d full=%0d",
                                 $time, out_item.out_x, out_item.out_y, out_item.out_z,
                                 out_item.case_code, out_item.table_full);
                    fail_total++;
                end
                else
                begin
                    want = expected_translations.pop_front();
                    if (out_item.out_x !== want.out_x || out_item.out_y !== want.out_y ||
                        out_item.out_z !== want.out_z ||
                        out_item.case_code !== want.case_code ||
                        out_item.table_full !== want.table_full)
                    begin
                        if (fail_total < 10)
                        begin
                            $display("mismatch at %0t: expected x=%h y=%h z=%h case=%0d full=%0d",
                                     $time, want.out_x, want.out_y, want.out_z,
                                     want.case_code, want.table_full);
                            $display("                   got x=%h y=%h z=%h case=%0d full=%0d",
                                     out_item.out_x, out_item.out_y, out_item.out_z,
                                     out_item.case_code, out_item.table_full);
                        end
                        fail_total++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_translations.insert(expected_translations.size(),
                                             apply_command(in_item));
            outstanding <= expected_translations.size();
            mismatches  <= fail_total;
        end
    end

endmodule

/* dv/keyframe_position_lerp_tb.sv */
// ----------------------------------------------------------------------------
// keyframe_position_lerp_tb
// Drives append, clear and query commands into the keyframe track under
// three idle profiles and three fallback settings. A short directed list
// covers the edge cases of the table search; random tracks of sorted keys
// with query bursts and random noise commands follow. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module keyframe_position_lerp_tb;

    import kfl_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int                CYCLE_LIMIT = 1500000;
    localparam int                DRAIN_TAIL  = 200;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    kfl_in_t              in_item   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    kfl_out_t             out_item;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [POS_W-1:0]     cfg_data  = '0;

    int                   mismatches;
    int                   outstanding;
    int                   send_idle   = 0;
    int                   recv_idle   = 0;
    int                   beats_sent  = 0;
    int                   cycle_count = 0;
    logic [TICK_W-1:0]    key_ticks_now [KEYS_DEFAULT];
    int                   keys_now    = 0;

    keyframe_position_lerp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    keyframe_position_lerp_check track_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic kfl_in_t make_beat(
        logic [MODE_W-1:0] mode,
        logic [TICK_W-1:0] tick,
        logic [POS_W-1:0]  x,
        logic [POS_W-1:0]  y,
        logic [POS_W-1:0]  z
    );
        kfl_in_t beat;
        beat.mode  = mode;
        beat.tick  = tick;
        beat.key_x = x;
        beat.key_y = y;
        beat.key_z = z;
        return beat;
    endfunction

    function automatic logic [POS_W-1:0] rand_pos();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [TICK_W-1:0] pick_query_tick();
        logic [TICK_W-1:0] lo;
        logic [TICK_W-1:0] hi;
        if (keys_now == 0)
            return TICK_W'($urandom);
        lo = key_ticks_now[0];
        hi = key_ticks_now[keys_now-1];
        case ($urandom_range(5))
            0:       return key_ticks_now[$urandom_range(keys_now-1)];
            1, 2:    return TICK_W'($urandom_range(hi, lo));
            3:       return (lo == 0) ? '0 : TICK_W'($urandom_range(lo - 1, 0));
            4:       return TICK_W'($urandom_range(24'hFF_FFFF, hi));
            default: return TICK_W'($urandom);
        endcase
    endfunction

    task automatic push_beat(input kfl_in_t beat);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= beat;
        do
            @(posedge clk);
        while (!in_ready);
        if (beat.mode != MODE_UNUSED)
            beats_sent++;
        if (beat.mode == MODE_APPEND && keys_now < KEYS_DEFAULT)
        begin
            key_ticks_now[keys_now] = beat.tick;
            keys_now++;
        end
        else if (beat.mode == MODE_CLEAR)
        begin
            keys_now = 0;
        end
    endtask

    task automatic query(input logic [TICK_W-1:0] tick);
        push_beat(make_beat(MODE_QUERY, tick, $urandom, $urandom, $urandom));
    endtask

    task automatic append(input logic [TICK_W-1:0] tick, input logic [POS_W-1:0] x,
                          input logic [POS_W-1:0] y, input logic [POS_W-1:0] z);
        push_beat(make_beat(MODE_APPEND, tick, x, y, z));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_fallbacks(input logic [POS_W-1:0] fx, input logic [POS_W-1:0] fy,
                                   input logic [POS_W-1:0] fz);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FALLBACK_X;
        cfg_data  <= fx;
        @(posedge clk);
        cfg_index <= REG_FALLBACK_Y;
        cfg_data  <= fy;
        @(posedge clk);
        cfg_index <= REG_FALLBACK_Z;
        cfg_data  <= fz;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic enter_phase(input int s_idle, input int r_idle, input logic [POS_W-1:0] fx,
                               input logic [POS_W-1:0] fy, input logic [POS_W-1:0] fz);
        drain();
        write_fallbacks(fx, fy, fz);
        send_idle = s_idle;
        recv_idle = r_idle;
        push_beat(make_beat(MODE_CLEAR, TICK_W'($urandom), $urandom, $urandom, $urandom));
        query(TICK_W'($urandom));
    endtask

    task automatic query_burst();
        repeat ($urandom_range(10, 3))
            query(pick_query_tick());
    endtask

    task automatic build_track();
        int n;
        int t;
        int stride_kind;
        int step;
        int r;
        push_beat(make_beat(MODE_CLEAR, TICK_W'($urandom), $urandom, $urandom, $urandom));
        r = $urandom_range(99);
        if (r < 60)
            n = $urandom_range(8, 1);
        else if (r < 90)
            n = $urandom_range(32, 9);
        else if (r < 97)
            n = $urandom_range(KEYS_DEFAULT, 33);
        else
            n = $urandom_range(KEYS_DEFAULT + 4, KEYS_DEFAULT + 1);
        t = ($urandom_range(1) == 0) ? $urandom_range(1000) : $urandom_range(24'hFF_FFFF);
        stride_kind = $urandom_range(2);
        for (int k = 0; k < n; k++)
        begin
            append(TICK_W'(t), rand_pos(), rand_pos(), rand_pos());
            case (stride_kind)
                0:       step = ($urandom_range(3) == 0) ? 0 : $urandom_range(64, 1);
                1:       step = $urandom_range(1 << 18, 1);
                default: step = ($urandom_range(1) == 0) ? $urandom_range(16) :
                                                           $urandom_range(1 << 22, 1);
            endcase
            t = t + step;
            if (t > 24'hFF_FFFF)
                t = 24'hFF_FFFF;
        end
        repeat ($urandom_range(2, 1))
            query_burst();
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(6, 1))
            push_beat(make_beat(MODE_W'($urandom_range(3)), TICK_W'($urandom), rand_pos(),
                                rand_pos(), rand_pos()));
        query_burst();
    endtask

    task automatic random_until(input int goal);
        int  mid;
        bit  held;
        mid  = beats_sent + (goal - beats_sent) / 2;
        held = 1'b0;
        while (beats_sent < goal)
        begin
            if ($urandom_range(99) < 75)
                build_track();
            else
                noise_burst();
            if (!held && beats_sent >= mid)
            begin
                drain();
                held = 1'b1;
            end
        end
    endtask

    task automatic directed_checks();
        query(24'd0);
        push_beat(make_beat(MODE_UNUSED, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF));
        append(24'd100, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        query(24'd0);
        query(24'd100);
        append(24'hFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        query(24'd99);
        query(24'd100);
        query(24'h80_0000);
        query(24'hFF_FFFE);
        query(24'hFF_FFFF);
        append(24'd50, 32'h0001_0000, 32'hFFFF_0000, 32'd7);
        query(24'd60);
        query(24'd200);
        push_beat(make_beat(MODE_CLEAR, 24'd0, 32'd0, 32'd0, 32'd0));
        query(24'd5);
        append(24'd10, 32'd0, 32'd0, 32'd0);
        append(24'd10, 32'd1000, -32'sd1000, 32'd5);
        append(24'd20, -32'sd5, 32'd5, 32'h7FFF_FFFF);
        query(24'd10);
        query(24'd15);
        query(24'd20);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        enter_phase(19, 71, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        directed_checks();
        random_until(633);
        enter_phase(71, 19, $urandom, $urandom, $urandom);
        random_until(1266);
        enter_phase(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        random_until(1900);
        drain();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
